>>> rtl/core/mmrh_pkg.sv
// Shared types, constants and micro-program table for the multiply-rotate hash.
`timescale 1ns / 1ps
package mmrh_pkg;

  localparam logic [63:0] K_P = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [63:0] K_Q = 64'd13166748625691186689;
  localparam logic [63:0] K_R = 64'd1573836600196043749;
  localparam logic [63:0] K_S = 64'd1478582680485693857;
  localparam logic [63:0] K_T = 64'd1584163446043636637;
  localparam logic [63:0] K_U = 64'd1358537349836140151;
  localparam logic [63:0] K_V = 64'd2849285319520710901;
  localparam logic [63:0] K_W = 64'd2366157163652459183;

  localparam logic CFG_SEED = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  localparam logic [1:0] MODE_128 = 2'd1;
  localparam logic [1:0] MODE_256 = 2'd2;

  // Program entry points
  localparam logic [4:0] PC_TAIL = 5'd0;
  localparam logic [4:0] PC_EVEN = 5'd15;
  localparam logic [4:0] PC_ODD  = 5'd17;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [63:0]      base;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [3:0][63:0] tail;
  } cmd_t;

  typedef enum logic [2:0] {
    OP_MR,
    OP_SEED,
    OP_ROT,
    OP_ADDT,
    OP_EMIT,
    OP_END
  } op_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_INIT,
    B_PREP,
    B_FETCH,
    B_LOAD,
    B_MUL,
    B_WRITE
  } bstate_e;

  function automatic op_e prog_op(logic [4:0] pc);
    op_e op;
    case (pc)
      5'd0:    op = OP_SEED;
      5'd1:    op = OP_ADDT;
      5'd2:    op = OP_MR;
      5'd3:    op = OP_SEED;
      5'd4:    op = OP_MR;
      5'd5:    op = OP_EMIT;
      5'd6:    op = OP_MR;
      5'd7:    op = OP_EMIT;
      5'd8:    op = OP_MR;
      5'd9:    op = OP_SEED;
      5'd10:   op = OP_MR;
      5'd11:   op = OP_EMIT;
      5'd12:   op = OP_MR;
      5'd13:   op = OP_EMIT;
      5'd15:   op = OP_MR;
      5'd17:   op = OP_SEED;
      5'd18:   op = OP_ROT;
      default: op = OP_END;
    endcase
    return op;
  endfunction

  // Multiplier constant of one mul-rotate-mul step
  function automatic logic [63:0] mrm_k(logic seeded, logic [1:0] sub, logic pass);
    logic [63:0] k;
    if (seeded) begin
      if (sub == 2'd0) k = pass ? K_W : K_V;
      else             k = pass ? K_S : K_R;
    end else begin
      case (sub)
        2'd0:    k = pass ? K_Q : K_P;
        2'd1:    k = pass ? K_S : K_R;
        2'd2:    k = pass ? K_U : K_T;
        default: k = pass ? K_W : K_V;
      endcase
    end
    return k;
  endfunction

  function automatic logic [63:0] mrm_ror(logic [63:0] x, logic seeded, logic [1:0] sub);
    logic [63:0] r;
    if (seeded) begin
      r = {x[22:0], x[63:23]};
    end else begin
      case (sub)
        2'd0:    r = {x[22:0], x[63:23]};
        2'd1:    r = {x[28:0], x[63:29]};
        2'd2:    r = {x[30:0], x[63:31]};
        default: r = {x[36:0], x[63:37]};
      endcase
    end
    return r;
  endfunction

  function automatic logic [5:0] tail_shift(int k);
    logic [5:0] s;
    case (k)
      2:       s = 6'd8;
      3:       s = 6'd16;
      4:       s = 6'd24;
      5:       s = 6'd32;
      6:       s = 6'd40;
      7:       s = 6'd48;
      9:       s = 6'd8;
      10:      s = 6'd16;
      11:      s = 6'd24;
      12:      s = 6'd32;
      13:      s = 6'd40;
      14:      s = 6'd48;
      15:      s = 6'd56;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/mmrh_front.sv
// Front end: takes input beats, seeds the base and spreads the tail bytes.
`timescale 1ns / 1ps
module mmrh_front
  import mmrh_pkg::*;
(
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_item_i,
  input  logic [63:0] total_length_i,
  input  logic [63:0] block_low_word_i,
  input  logic [63:0] block_high_word_i,
  input  logic [3:0]  tail_count_i,
  input  logic        last_item_i,
  input  logic [63:0] seed_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output cmd_t        q_data_o
);

  logic [127:0]     blk;
  logic [3:0][63:0] tail;
  logic [7:0]       tbyte;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign blk        = {block_high_word_i, block_low_word_i};

  // Tail bytes land on disjoint byte lanes, so OR them together
  always_comb begin
    tail  = '0;
    tbyte = '0;
    for (int k = 1; k <= 15; k++) begin
      tbyte = blk[8*(k-1) +: 8];
      if (4'(k) <= tail_count_i) begin
        tail[2'((15 - k) & 3)] = tail[2'((15 - k) & 3)] |
                                 ({56'd0, tbyte} << tail_shift(k));
      end
    end
  end

  always_comb begin
    q_data_o.first = first_item_i;
    q_data_o.last  = last_item_i;
    q_data_o.base  = seed_i + total_length_i;
    q_data_o.lo    = block_low_word_i;
    q_data_o.hi    = block_high_word_i;
    q_data_o.tail  = tail;
  end

endmodule

>>> rtl/core/mmrh_queue.sv
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
module mmrh_queue
  import mmrh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output cmd_t data_o
);

  cmd_t       mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/mmrh_back.sv
// Back end: sequencer over the chain words with a shared 32x32 multiplier.
`timescale 1ns / 1ps
module mmrh_back
  import mmrh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] seed_i,
  input  logic [1:0]  mode_i,
  input  logic        q_valid_i,
  input  cmd_t        q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  bstate_e          st_q, st_d;
  logic [3:0][63:0] w_q, w_d;
  logic             parity_q, parity_d;
  logic [4:0]       pc_q, pc_d;
  logic [1:0]       sub_q, sub_d;
  logic             pass_q, pass_d;
  logic [1:0]       ph_q, ph_d;
  logic [1:0]       emit_k_q, emit_k_d;
  logic             out_valid_q, out_valid_d;
  cmd_t             cmd_q, cmd_d;
  logic [63:0]      x_q, x_d;
  logic [63:0]      prod_q, prod_d;
  logic [63:0]      acc_q, acc_d;
  logic [63:0]      dig_q, dig_d;
  logic [1:0]       idx_q, idx_d;
  logic             lastw_q, lastw_d;

  op_e         op;
  logic        seeded;
  logic        out_free;
  logic        out_load;
  logic        emit_last;
  logic [63:0] kmul;
  logic [31:0] ma, mb;
  logic [63:0] mul_res;
  logic [63:0] sum_r;
  logic [63:0] src_w, xor_w;

  assign op       = prog_op(pc_q);
  assign seeded   = (op == OP_SEED);
  assign out_free = !out_valid_q || !out_stall_i;
  assign kmul     = mrm_k(seeded, sub_q, pass_q);
  assign sum_r    = acc_q + {prod_q[31:0], 32'd0};

  always_comb begin
    case (mode_i)
      MODE_128: emit_last = (emit_k_q == 2'd1);
      MODE_256: emit_last = (emit_k_q == 2'd3);
      default:  emit_last = (emit_k_q == 2'd0);
    endcase
  end

  // One partial product per cycle; the high-by-high term lies wholly at bit 64 and up, so it is skipped
  always_comb begin
    case (ph_q)
      2'd1:    begin ma = x_q[31:0];  mb = kmul[63:32]; end
      2'd2:    begin ma = x_q[63:32]; mb = kmul[31:0];  end
      default: begin ma = x_q[31:0];  mb = kmul[31:0];  end
    endcase
    mul_res = {32'd0, ma} * {32'd0, mb};
  end

  always_comb begin
    if (seeded) begin
      src_w = (sub_q == 2'd0) ? w_q[1] : w_q[2];
      xor_w = (sub_q == 2'd0) ? 64'd0 : (w_q[1] + seed_i);
    end else begin
      src_w = w_q[sub_q];
      xor_w = sub_q[0] ? w_q[sub_q - 2'd1] : 64'd0;
    end
  end

  always_comb begin
    st_d        = st_q;
    w_d         = w_q;
    parity_d    = parity_q;
    pc_d        = pc_q;
    sub_d       = sub_q;
    pass_d      = pass_q;
    ph_d        = ph_q;
    emit_k_d    = emit_k_q;
    cmd_d       = cmd_q;
    x_d         = x_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    case (st_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          st_d    = B_INIT;
        end
      end
      B_INIT: begin
        if (cmd_q.first) begin
          w_d[0]   = cmd_q.base + 64'd1;
          w_d[1]   = cmd_q.base + 64'd2;
          w_d[2]   = cmd_q.base + 64'd3;
          w_d[3]   = cmd_q.base + 64'd5;
          parity_d = 1'b0;
        end
        st_d = B_PREP;
      end
      B_PREP: begin
        if (!cmd_q.last) begin
          w_d[0] = w_q[0] - cmd_q.lo;
          w_d[1] = w_q[1] + cmd_q.lo;
          w_d[2] = w_q[2] + cmd_q.hi;
          w_d[3] = w_q[3] - cmd_q.hi;
          pc_d   = parity_q ? PC_ODD : PC_EVEN;
        end else begin
          pc_d = PC_TAIL;
        end
        emit_k_d = 2'd0;
        st_d     = B_FETCH;
      end
      B_FETCH: begin
        case (op)
          OP_MR, OP_SEED: begin
            sub_d = 2'd0;
            st_d  = B_LOAD;
          end
          OP_ROT: begin
            w_d[0] = w_q[3];
            w_d[1] = w_q[0];
            w_d[2] = w_q[1];
            w_d[3] = w_q[2];
            pc_d   = pc_q + 5'd1;
          end
          OP_ADDT: begin
            for (int i = 0; i < 4; i++) begin
              w_d[i] = w_q[i] + cmd_q.tail[i];
            end
            pc_d = pc_q + 5'd1;
          end
          OP_EMIT: begin
            // Hold here until the output register frees up
            if (out_free) begin
              out_load = 1'b1;
              if (emit_last) begin
                st_d = B_IDLE;
              end else begin
                emit_k_d = emit_k_q + 2'd1;
                pc_d     = pc_q + 5'd1;
              end
            end
          end
          OP_END: begin
            parity_d = !parity_q;
            st_d     = B_IDLE;
          end
          default: st_d = B_IDLE;
        endcase
      end
      B_LOAD: begin
        x_d    = src_w ^ xor_w;
        pass_d = 1'b0;
        ph_d   = 2'd0;
        st_d   = B_MUL;
      end
      B_MUL: begin
        prod_d = mul_res;
        ph_d   = ph_q + 2'd1;
        case (ph_q)
          2'd1: acc_d = prod_q;
          2'd2: acc_d = sum_r;
          2'd3: begin
            if (!pass_q) begin
              x_d    = mrm_ror(sum_r, seeded, sub_q);
              pass_d = 1'b1;
            end else begin
              x_d  = sum_r;
              st_d = B_WRITE;
            end
          end
          default: ;
        endcase
      end
      B_WRITE: begin
        if (seeded) begin
          w_d[1] = x_q;
          if (sub_q == 2'd1) w_d[2] = w_q[1];
        end else begin
          w_d[sub_q] = x_q;
        end
        if ((seeded && sub_q == 2'd1) || (!seeded && sub_q == 2'd3)) begin
          pc_d = pc_q + 5'd1;
          st_d = B_FETCH;
        end else begin
          sub_d = sub_q + 2'd1;
          st_d  = B_LOAD;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    dig_d       = dig_q;
    idx_d       = idx_q;
    lastw_d     = lastw_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      dig_d       = 64'd0 - w_q[2] - w_q[3];
      idx_d       = emit_k_q;
      lastw_d     = emit_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      w_q         <= '0;
      parity_q    <= 1'b0;
      pc_q        <= 5'd0;
      sub_q       <= 2'd0;
      pass_q      <= 1'b0;
      ph_q        <= 2'd0;
      emit_k_q    <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      w_q         <= w_d;
      parity_q    <= parity_d;
      pc_q        <= pc_d;
      sub_q       <= sub_d;
      pass_q      <= pass_d;
      ph_q        <= ph_d;
      emit_k_q    <= emit_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    x_q     <= x_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    dig_q   <= dig_d;
    idx_q   <= idx_d;
    lastw_q <= lastw_d;
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = dig_q;
  assign word_index_o  = idx_q;
  assign last_word_o   = lastw_q;

`ifndef NO_ASSERTIONS
  a_phase_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != 2'd0) |-> (st_q == B_MUL))
    else $error("multiplier phase active outside multiply state");

  a_last_word_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && emit_last) |=> (st_q == B_IDLE))
    else $error("sequencer did not finish after final digest word");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(st_q) == B_FETCH && $past(op) == OP_EMIT))
    else $error("output loaded outside an emit step");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (q_valid_i && st_q == B_IDLE))
    else $error("queue popped while busy or empty");
`endif

endmodule

>>> rtl/core/mix_multiply_rotate_hash.sv
// Top level of the streaming multiply-rotate hash.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one 16-byte block per beat;
//   first_item_i seeds the chain from total_length_i, last_item_i carries the
//   0 to 15 tail bytes and triggers the digest.
//   Output channel (out_valid_o / out_stall_i) returns 1, 2 or 4 digest words
//   for digest_mode 0, 1 or 2, word_index_o counting up, last_word_o on the
//   final one.
//   Configuration (cfg_valid_i / cfg_ready_o) writes hash_seed (index 0) or
//   digest_mode (index 1); write only while the block is idle.
// Datapath: every 64-bit constant multiply is built from the low-by-low,
//   low-by-high and high-by-low partial products of one 32x32 multiplier.
//   Blocks alternate between the multiply-rotate mixer and the seeded mixer;
//   a last item runs further steps for 128 or 256-bit digests. A two-entry
//   queue lets the front take two more beats while one runs.
// Reset clears the chain words, the mixer parity, the queue and the configuration registers.
// A stalled output word holds; the sequencer waits at the next emit step.
module mix_multiply_rotate_hash
  import mmrh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_item_i,
  input  logic [63:0] total_length_i,
  input  logic [63:0] block_low_word_i,
  input  logic [63:0] block_high_word_i,
  input  logic [3:0]  tail_count_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  logic [63:0] seed_q, seed_d;
  logic [1:0]  mode_q, mode_d;
  logic        q_full, q_push, q_pop, q_valid;
  cmd_t        q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    seed_d = seed_q;
    mode_d = mode_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SEED: seed_d = cfg_data_i;
        CFG_MODE: mode_d = cfg_data_i[1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= 64'd0;
      mode_q <= 2'd0;
    end else begin
      seed_q <= seed_d;
      mode_q <= mode_d;
    end
  end

  mmrh_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .first_item_i      (first_item_i),
    .total_length_i    (total_length_i),
    .block_low_word_i  (block_low_word_i),
    .block_high_word_i (block_high_word_i),
    .tail_count_i      (tail_count_i),
    .last_item_i       (last_item_i),
    .seed_i            (seed_q),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_data_o          (q_in)
  );

  mmrh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (q_out)
  );

  mmrh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_i        (seed_q),
    .mode_i        (mode_q),
    .q_valid_i     (q_valid),
    .q_data_i      (q_out),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the streaming multiply-rotate hash.
`timescale 1ns / 1ps
module testbench
  import mmrh_pkg::*;
();

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        fin;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_SEED;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        first_item_i = 1'b0;
  logic [63:0] total_length_i = '0;
  logic [63:0] block_low_word_i = '0;
  logic [63:0] block_high_word_i = '0;
  logic [3:0]  tail_count_i = '0;
  logic        last_item_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  mix_multiply_rotate_hash u_top (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state
  logic [63:0]  chain [4];
  logic         odd_step;
  logic [63:0]  seed_reg;
  logic [1:0]   mode_reg;
  digest_beat_t digest_q [$];
  int           errors;
  bit           quiet_sink;
  bit           sink_hold;
  bit           burst_hold;
  bit           idle_send;

  function automatic logic [63:0] rotr(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic mix_mr();
    logic [63:0] a, b, c, d;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    a = a * K_P; a = rotr(a, 23); a = a * K_Q;
    b = b ^ a;
    b = b * K_R; b = rotr(b, 29); b = b * K_S;
    c = c * K_T; c = rotr(c, 31); c = c * K_U;
    d = d ^ c;
    d = d * K_V; d = rotr(d, 37); d = d * K_W;
    chain[0] = a; chain[1] = b; chain[2] = c; chain[3] = d;
  endtask

  task automatic mix_sd();
    logic [63:0] a, b;
    a = chain[1]; b = chain[2];
    a = a * K_V; a = rotr(a, 23); a = a * K_W;
    b = b ^ (a + seed_reg);
    b = b * K_R; b = rotr(b, 23); b = b * K_S;
    chain[1] = b; chain[2] = a;
  endtask

  task automatic push_word(int k, bit fin);
    digest_beat_t e;
    e.word = 64'd0 - chain[2] - chain[3];
    e.idx = 2'(k);
    e.fin = fin;
    digest_q = {digest_q, e};
  endtask

  // Work out the digest words one accepted beat causes
  task automatic predict_hash(logic fi, logic [63:0] len, logic [63:0] lo,
                              logic [63:0] hi, logic [3:0] cnt, logic la);
    logic [63:0] base, t, byt;
    int          sh;
    if (fi) begin
      base = seed_reg + len;
      chain[0] = base + 1; chain[1] = base + 2;
      chain[2] = base + 3; chain[3] = base + 5;
      odd_step = 1'b0;
    end
    if (!la) begin
      chain[0] -= lo; chain[1] += lo; chain[2] += hi; chain[3] -= hi;
      if (odd_step) begin
        mix_sd();
        t = chain[3]; chain[3] = chain[2]; chain[2] = chain[1];
        chain[1] = chain[0]; chain[0] = t;
      end else begin
        mix_mr();
      end
      odd_step = ~odd_step;
      return;
    end
    mix_sd();
    for (int k = 1; k <= cnt; k++) begin
      byt = (k <= 8) ? ((lo >> (8 * (k - 1))) & 64'hFF) : ((hi >> (8 * (k - 9))) & 64'hFF);
      sh = (k == 1 || k == 8) ? 0 : (k < 8 ? 8 * (k - 1) : 8 * (k - 8));
      chain[(15 - k) & 3] += byt << sh;
    end
    mix_mr(); mix_sd(); mix_mr();
    if (mode_reg == MODE_128) begin
      push_word(0, 0); mix_mr(); push_word(1, 1);
    end else if (mode_reg == MODE_256) begin
      push_word(0, 0); mix_mr(); push_word(1, 0);
      mix_mr(); mix_sd(); mix_mr(); push_word(2, 0);
      mix_mr(); push_word(3, 1);
    end else begin
      push_word(0, 1);
    end
  endtask

  // Valid stays high after an accepted beat so beats can follow back to back
  task automatic send_beat(logic fi, logic [63:0] len, logic [63:0] lo,
                           logic [63:0] hi, logic [3:0] cnt, logic la);
    if (idle_send && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_item_i <= fi;
    total_length_i <= len;
    block_low_word_i <= lo;
    block_high_word_i <= hi;
    tail_count_i <= cnt;
    last_item_i <= la;
    do @(posedge clk_i); while (in_stall_o);
    predict_hash(fi, len, lo, hi, cnt, la);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_SEED) seed_reg = val;
    else mode_reg = val[1:0];
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_message(int blocks);
    send_beat(1'b1, rnd64(), rnd64(), rnd64(), 4'(blocks == 0 ? $urandom_range(0, 15) : 0),
              blocks == 0);
    for (int b = 1; b < blocks; b++)
      send_beat(1'b0, rnd64(), rnd64(), rnd64(), 4'($urandom()), 1'b0);
    if (blocks != 0)
      send_beat(1'b0, rnd64(), rnd64(), rnd64(), 4'($urandom()), 1'b1);
  endtask

  // Extremes, each tail length, headless and single-beat messages
  task automatic test_directed();
    send_beat(1'b0, '0, '1, '1, 4'd0, 1'b0);
    send_beat(1'b0, '1, '0, '1, 4'd15, 1'b1);
    send_beat(1'b1, '1, '1, '1, 4'd15, 1'b1);
    send_beat(1'b1, '0, '0, '0, 4'd0, 1'b1);
    send_beat(1'b1, 64'd33, '1, '0, 4'd3, 1'b0);
    send_beat(1'b0, '0, 64'h0123_4567_89AB_CDEF, '1, 4'd0, 1'b0);
    send_beat(1'b0, '0, '1, '1, 4'd0, 1'b0);
    send_beat(1'b0, '0, '1, '1, 4'd8, 1'b1);
    for (int t = 0; t < 16; t++)
      send_beat(1'b1, 64'(t), rnd64(), rnd64(), 4'(t), 1'b1);
    drain();
  endtask

  task automatic test_modes();
    logic [63:0] seeds [3] = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
    for (int m = 0; m < 4; m++) begin
      write_reg(CFG_SEED, m == 3 ? rnd64() : seeds[m % 3]);
      write_reg(CFG_MODE, 64'(m));
      send_message(0);
      send_message(3);
      drain();
    end
  endtask

  task automatic test_random();
    idle_send = 1'b1;
    for (int m = 0; m < 16; m++) begin
      if (m % 5 == 0) begin
        drain();
        write_reg(CFG_SEED, rnd64());
        write_reg(CFG_MODE, 64'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 7) == 0)
        send_beat($urandom_range(0, 1), rnd64(), rnd64(), rnd64(), 4'($urandom()),
                  $urandom_range(0, 1));
      else
        send_message($urandom_range(0, 6));
    end
    drain();
  endtask

  // Hold the sink off while beats pile up, then send after a full drain
  task automatic test_backpressure();
    write_reg(CFG_MODE, 64'(MODE_256));
    fork
      begin
        sink_hold = 1'b1;
        repeat (1500) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      for (int m = 0; m < 4; m++) send_message(1);
    join
    drain();
    idle_send = 1'b0;
    quiet_sink = 1'b1;
    for (int m = 0; m < 4; m++) send_message($urandom_range(0, 3));
    drain();
  endtask

  always @(posedge clk_i) begin
    if (sink_hold || (!quiet_sink && (burst_hold || $urandom_range(0, 5) == 0)))
      out_stall_i <= 1'b1;
    else
      out_stall_i <= 1'b0;
  end

  task automatic sink_hold_burst(int n);
    burst_hold = 1'b1;
    repeat (n) @(posedge clk_i);
    burst_hold = 1'b0;
  endtask

  // Random stall bursts on the sink
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet_sink && $urandom_range(0, 20) == 0) begin
        sink_hold_burst(int'($urandom_range(1, 13)));
      end
    end
  end

  always @(posedge clk_i) begin
    digest_beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t unexpected digest word %h", $time, digest_word_o);
        errors++;
      end else begin
        e = digest_q.pop_front();
        if (digest_word_o !== e.word || word_index_o !== e.idx || last_word_o !== e.fin) begin
          $display("%0t mismatch: expected %h/%0d/%0d actual %h/%0d/%0d", $time, e.word,
                   e.idx, e.fin, digest_word_o, word_index_o, last_word_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    errors = 0;
    seed_reg = '0; mode_reg = '0; odd_step = 1'b0;
    for (int i = 0; i < 4; i++) chain[i] = '0;
    quiet_sink = 1'b0; sink_hold = 1'b0; burst_hold = 1'b0; idle_send = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_modes();
    test_random();
    test_backpressure();
    if (errors == 0 && digest_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

>>> sim.f
rtl/core/mmrh_pkg.sv
rtl/core/mmrh_front.sv
rtl/core/mmrh_queue.sv
rtl/core/mmrh_back.sv
rtl/core/mix_multiply_rotate_hash.sv
tb/testbench.sv
